/* rtl/gpcr_pkg.sv */
// ----------------------------------------------------------------------------
// Game port counter registers package
// Shared types, command codes, register offsets and constants for the two
// game ports.
// ----------------------------------------------------------------------------
package gpcr_pkg;

  // Default width of the wrapping mouse position counters.
  localparam int unsigned CounterWidthDefault = 32;

  // Largest step that one JOYxDAT read moves a reported position.
  localparam int StepLimit = 127;

  // Command codes carried by each input word.
  localparam logic [1:0] CmdRead     = 2'd0;
  localparam logic [1:0] CmdJoytest  = 2'd1;
  localparam logic [1:0] CmdMouse    = 2'd2;
  localparam logic [1:0] CmdJoystick = 2'd3;

  // Custom register offsets that a read can address.
  localparam logic [8:0] OffJoy0Dat = 9'h00A;
  localparam logic [8:0] OffJoy1Dat = 9'h00C;
  localparam logic [8:0] OffPot0Dat = 9'h012;
  localparam logic [8:0] OffPot1Dat = 9'h014;
  localparam logic [8:0] OffPotgor  = 9'h016;

  // Pot counter and POTGOR constants.
  localparam logic [15:0] PotStep         = 16'h0100;
  localparam logic [15:0] PotGoBits       = 16'hFFFF;
  localparam logic [15:0] PotgorMask      = 16'hBBFF;
  localparam logic [15:0] Fire0Released   = 16'h0400;
  localparam logic [15:0] Fire1Released   = 16'h4000;

  // One input word as it is held in the input register.
  typedef struct packed {
    logic [1:0]         command;
    logic               port;
    logic [8:0]         reg_offset;
    logic [15:0]        write_data;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [3:0]         dir;      // bit 0 left, 1 up, 2 right, 3 down
    logic               fire_secondary;
  } item_t;

  // Quadrature code that a joystick-mode JOYxDAT read returns.
  function automatic logic [15:0] joy_code(input logic [3:0] dir);
    logic [15:0] r;
    r = 16'h0000;
    if (dir[2]) r = r | 16'h0003;
    if (dir[0]) r = r | 16'h0300;
    if (dir[1]) r = r ^ 16'h0100;
    if (dir[3]) r = r ^ 16'h0001;
    return r;
  endfunction

endpackage

/* rtl/game_port_counter_registers.sv */
// ----------------------------------------------------------------------------
// Game port counter registers
// Two game ports with mouse position counters, joystick direction latches,
// pot counters and the JOYxDAT / POTxDAT / POTGOR read path.
// ----------------------------------------------------------------------------
// Reads: an accepted read word waits in the input register, and its result
// is loaded into the output register at the edge that retires it.
// Throughput: one word per cycle; the input register stalls only when it
// holds a read while the output register is full and stalled.
// Reset: all counters, direction bits and button history clear; port 0 comes
// up in mouse mode and port 1 in joystick mode.
module game_port_counter_registers
  import gpcr_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input words.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic        port_i,
  input  logic [8:0]  reg_offset_i,
  input  logic [15:0] write_data_i,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_y_i,
  input  logic        stick_left_i,
  input  logic        stick_up_i,
  input  logic        stick_right_i,
  input  logic        stick_down_i,
  input  logic        fire_secondary_i,

  // Result words.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,

  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam logic signed [CW-1:0] LimPos = CW'(StepLimit);
  localparam logic signed [CW-1:0] LimNeg = CW'(-StepLimit);

  // The reported position moves toward the true one by at most the step
  // limit. The distance is taken as a signed value so a wrap goes the short
  // way round.
  function automatic logic [CW-1:0] approach(input logic [CW-1:0] truth,
                                             input logic [CW-1:0] rep);
    logic signed [CW-1:0] d;
    d = $signed(truth - rep);
    if (d > LimPos) begin
      d = LimPos;
    end else if (d < LimNeg) begin
      d = LimNeg;
    end
    return rep + $unsigned(d);
  endfunction

  // --------------------------------------------------------------------------
  // Handshake. Stage one is the input register; the work is done while the
  // word sits there, and state updates at the edge that retires it. A read
  // retires only when the output register can take its result.
  // --------------------------------------------------------------------------
  item_t s1_q;
  logic  s1_valid_q;
  logic  out_valid_q;
  logic [15:0] out_data_q;
  logic  out_free;
  logic  s1_is_read;
  logic  s1_go;
  logic  in_take;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_is_read  = (s1_q.command == CmdRead);
  assign s1_go       = s1_valid_q && (!s1_is_read || out_free);
  assign in_stall_o  = s1_valid_q && !s1_go;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || s1_go) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.command        <= command_i;
      s1_q.port           <= port_i;
      s1_q.reg_offset     <= reg_offset_i;
      s1_q.write_data     <= write_data_i;
      s1_q.delta_x        <= delta_x_i;
      s1_q.delta_y        <= delta_y_i;
      s1_q.dir            <= {stick_down_i, stick_right_i, stick_up_i, stick_left_i};
      s1_q.fire_secondary <= fire_secondary_i;
    end
  end

  // --------------------------------------------------------------------------
  // Port mode registers, written over the configuration channel.
  // --------------------------------------------------------------------------
  logic [1:0] mouse_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mouse_mode_q <= 2'b01;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mouse_mode_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Per-port state. Each port has its own copy of the logic so nothing is
  // looked up by a port number computed at run time.
  // --------------------------------------------------------------------------
  logic [CW-1:0] pos_x_q [2];
  logic [CW-1:0] pos_y_q [2];
  logic [CW-1:0] rep_x_q [2];
  logic [CW-1:0] rep_y_q [2];
  logic [15:0]   pot_q   [2];
  logic [3:0]    dir_q   [2];
  logic [1:0]    held_q;

  logic [CW-1:0] pos_x_d [2];
  logic [CW-1:0] pos_y_d [2];
  logic [CW-1:0] rep_x_d [2];
  logic [CW-1:0] rep_y_d [2];
  logic [15:0]   pot_d   [2];
  logic [3:0]    dir_d   [2];
  logic [1:0]    held_d;

  logic [CW-1:0] rep_x_next [2];
  logic [CW-1:0] rep_y_next [2];
  logic [CW-1:0] dx_ext;
  logic [CW-1:0] dy_ext;
  logic [CW-1:0] jt_x;
  logic [CW-1:0] jt_y;
  logic [8:0]    joy_off [2];
  logic          is_event;
  logic          is_mouse;
  logic          is_joystick;
  logic          is_joytest;
  logic          port_hit;
  logic          joy_read;

  assign joy_off[0] = OffJoy0Dat;
  assign joy_off[1] = OffJoy1Dat;

  // JOYTEST bytes and mouse deltas are sign-extended to counter width.
  assign jt_x   = CW'($signed(s1_q.write_data[7:0]));
  assign jt_y   = CW'($signed(s1_q.write_data[15:8]));
  assign dx_ext = CW'(s1_q.delta_x);
  assign dy_ext = CW'(s1_q.delta_y);

  assign is_mouse    = s1_q.command == CmdMouse;
  assign is_joystick = s1_q.command == CmdJoystick;
  assign is_joytest  = s1_q.command == CmdJoytest;
  assign is_event    = is_mouse || is_joystick;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rep_x_next[k] = approach(pos_x_q[k], rep_x_q[k]);
      rep_y_next[k] = approach(pos_y_q[k], rep_y_q[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      port_hit = (s1_q.port == 1'(k));
      joy_read = s1_is_read && (s1_q.reg_offset == joy_off[k]) && mouse_mode_q[k];

      pos_x_d[k] = pos_x_q[k];
      pos_y_d[k] = pos_y_q[k];
      rep_x_d[k] = rep_x_q[k];
      rep_y_d[k] = rep_y_q[k];
      pot_d[k]   = pot_q[k];
      dir_d[k]   = dir_q[k];
      held_d[k]  = held_q[k];

      if (is_joytest) begin
        pos_x_d[k] = jt_x;
        pos_y_d[k] = jt_y;
        rep_x_d[k] = jt_x;
        rep_y_d[k] = jt_y;
      end else if (joy_read) begin
        rep_x_d[k] = rep_x_next[k];
        rep_y_d[k] = rep_y_next[k];
      end

      if (is_event && port_hit) begin
        // A rising edge of the secondary button bumps the pot counter.
        if (!held_q[k] && s1_q.fire_secondary) begin
          pot_d[k] = pot_q[k] + PotStep;
        end
        held_d[k] = s1_q.fire_secondary;
        if (is_mouse) begin
          pos_x_d[k] = pos_x_q[k] + dx_ext;
          pos_y_d[k] = pos_y_q[k] + dy_ext;
        end else begin
          dir_d[k] = s1_q.dir;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        pos_x_q[k] <= '0;
        pos_y_q[k] <= '0;
        rep_x_q[k] <= '0;
        rep_y_q[k] <= '0;
        pot_q[k]   <= '0;
        dir_q[k]   <= '0;
      end
      held_q <= '0;
    end else if (s1_go) begin
      for (int k = 0; k < 2; k++) begin
        pos_x_q[k] <= pos_x_d[k];
        pos_y_q[k] <= pos_y_d[k];
        rep_x_q[k] <= rep_x_d[k];
        rep_y_q[k] <= rep_y_d[k];
        pot_q[k]   <= pot_d[k];
        dir_q[k]   <= dir_d[k];
      end
      held_q <= held_d;
    end
  end

  // --------------------------------------------------------------------------
  // Read mux. Mouse-mode JOYxDAT returns the low bytes of the freshly moved
  // reported position; unknown offsets read as zero.
  // --------------------------------------------------------------------------
  logic [15:0] rd_data;

  always_comb begin
    case (s1_q.reg_offset)
      OffJoy0Dat: begin
        rd_data = mouse_mode_q[0] ? {rep_y_next[0][7:0], rep_x_next[0][7:0]}
                                  : joy_code(dir_q[0]);
      end
      OffJoy1Dat: begin
        rd_data = mouse_mode_q[1] ? {rep_y_next[1][7:0], rep_x_next[1][7:0]}
                                  : joy_code(dir_q[1]);
      end
      OffPot0Dat: rd_data = pot_q[0];
      OffPot1Dat: rd_data = pot_q[1];
      OffPotgor: begin
        rd_data = (PotGoBits & PotgorMask)
                | (held_q[0] ? 16'h0000 : Fire0Released)
                | (held_q[1] ? 16'h0000 : Fire1Released);
      end
      default: rd_data = 16'h0000;
    endcase
  end

  // Output register: loads when a read retires, empties when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && s1_is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_is_read) begin
      out_data_q <= rd_data;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // Only reads may hold up the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_is_read) |-> !in_stall_o)
    else $error("non-read word stalled in the input register");

  // A new result only appears after a read retired from stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_go && s1_is_read))
    else $error("result appeared without a retiring read");

  // A retiring read never overwrites a result that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(s1_go && s1_is_read))
    else $error("read retired into a full output register");

  // Pot counters only ever move in steps of 0x100.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pot_q[0][7:0] == 8'h00) && (pot_q[1][7:0] == 8'h00))
    else $error("pot counter low byte is not zero");

endmodule
